/* sv/vtp_pkg.sv */
`default_nettype none
package vtp_pkg;

  localparam int VTP_DATA_WIDTH = 32;
  localparam int VTP_FRAC_BITS  = 16;
  localparam int FIELD_W        = 32;
  localparam int CFG_W          = 64;
  localparam int CFG_IDX_W      = 4;
  localparam int NUM_REGS       = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_R0_C01 = 4'd0,
    REG_R0_C23 = 4'd1,
    REG_R1_C01 = 4'd2,
    REG_R1_C23 = 4'd3,
    REG_R2_C01 = 4'd4,
    REG_R2_C23 = 4'd5,
    REG_R3_C01 = 4'd6,
    REG_R3_C23 = 4'd7
  } reg_idx_t;

  // Identity matrix: 1.0 on the diagonal in Q16.16.
  localparam logic [CFG_W-1:0] COEF_RESET [NUM_REGS] = '{
    64'd65536, 64'd0, 64'd281474976710656, 64'd0,
    64'd0, 64'd65536, 64'd0, 64'd281474976710656
  };

endpackage
`default_nettype wire

/* sv/vertex_transform_project.sv */
// Channel   Direction  Handshake            Payload
// in        input      in_valid / in_stall   in_x, in_y, in_z, in_w
// out       output     out_valid / out_stall out_x, out_y, out_z, out_w, w_was_zero, saturated
// cfg       input      cfg_we               cfg_index, cfg_data
//
// One vertex enters per cycle while in_stall is low.
// The divider resolves one quotient bit per stage.
// Reset is synchronous and active low; it empties the pipeline and loads the identity matrix.
// A stall at the output while a result is held freezes every stage, so nothing is lost or repeated.
`default_nettype none
module vertex_transform_project
  import vtp_pkg::*;
#(
  parameter int DATA_WIDTH = VTP_DATA_WIDTH,
  parameter int FRAC_BITS  = VTP_FRAC_BITS
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  wire  [FIELD_W-1:0]   in_x,
  input  wire  [FIELD_W-1:0]   in_y,
  input  wire  [FIELD_W-1:0]   in_z,
  input  wire  [FIELD_W-1:0]   in_w,
  output logic                 out_valid,
  input  wire                  out_stall,
  output logic [FIELD_W-1:0]   out_x,
  output logic [FIELD_W-1:0]   out_y,
  output logic [FIELD_W-1:0]   out_z,
  output logic [FIELD_W-1:0]   out_w,
  output logic                 w_was_zero,
  output logic                 saturated,
  input  wire                  cfg_we,
  input  wire  [CFG_IDX_W-1:0] cfg_index,
  input  wire  [CFG_W-1:0]     cfg_data
);

  localparam int DW = DATA_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int PW = 2 * DW;
  localparam int SW = PW + 2;
  localparam int QW = DW + F;

  localparam logic signed [SW-1:0] SUM_HI = SW'((64'sd1 <<< (DW - 1)) - 64'sd1);
  localparam logic signed [SW-1:0] SUM_LO = -SUM_HI - SW'(1);
  localparam logic signed [QW:0]   Q_HI   = (QW+1)'((64'sd1 <<< (DW - 1)) - 64'sd1);
  localparam logic signed [QW:0]   Q_LO   = -Q_HI - (QW+1)'(1);

  typedef struct packed {
    logic [DW-1:0] rem;
    logic [QW-1:0] nq;
    logic          neg;
  } lane_t;

  typedef struct packed {
    logic [2:0][DW-1:0] t;
    logic [DW-1:0]      w;
    logic [DW-1:0]      d;
    logic               wz;
    logic               sat;
  } side_t;

  logic [CFG_W-1:0] coef_r [NUM_REGS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) coef_r[i] <= COEF_RESET[i];
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_R0_C01: coef_r[0] <= cfg_data;
        REG_R0_C23: coef_r[1] <= cfg_data;
        REG_R1_C01: coef_r[2] <= cfg_data;
        REG_R1_C23: coef_r[3] <= cfg_data;
        REG_R2_C01: coef_r[4] <= cfg_data;
        REG_R2_C23: coef_r[5] <= cfg_data;
        REG_R3_C01: coef_r[6] <= cfg_data;
        REG_R3_C23: coef_r[7] <= cfg_data;
        default: ;
      endcase
    end
  end

  // The whole pipeline advances together unless a finished result is held.
  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  logic signed [DW-1:0] vin [4];
  assign vin[0] = signed'(in_x[DW-1:0]);
  assign vin[1] = signed'(in_y[DW-1:0]);
  assign vin[2] = signed'(in_z[DW-1:0]);
  assign vin[3] = signed'(in_w[DW-1:0]);

  // Stage A: sixteen products.
  logic signed [PW-1:0] prod_r [4][4];
  logic                 va_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 4; c++) begin
          prod_r[r][c] <= signed'(coef_r[r*2 + c/2][(c%2)*32 +: DW]) * vin[c];
        end
      end
    end
  end

  // Stage B: exact row sums.
  logic signed [SW-1:0] sum_r [4];
  logic                 vb_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 4; r++) begin
        sum_r[r] <= SW'(prod_r[r][0]) + SW'(prod_r[r][1])
                  + SW'(prod_r[r][2]) + SW'(prod_r[r][3]);
      end
    end
  end

  // Stage C: floor shift, clamp, divider setup. Index 0 of the divider arrays.
  lane_t lane_r [QW+1][3];
  side_t side_r [QW+1];
  logic  vd_r   [QW+1];

  logic signed [SW-1:0] shf   [4];
  logic [3:0][DW-1:0]   tc;
  logic [3:0]           clip;
  lane_t                lane0 [3];
  side_t                side0;

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      shf[r] = sum_r[r] >>> F;
      clip[r] = 1'b0;
      if (shf[r] > SUM_HI) begin
        tc[r] = SUM_HI[DW-1:0];
        clip[r] = 1'b1;
      end else if (shf[r] < SUM_LO) begin
        tc[r] = SUM_LO[DW-1:0];
        clip[r] = 1'b1;
      end else begin
        tc[r] = shf[r][DW-1:0];
      end
    end
    side0.t   = tc[2:0];
    side0.w   = tc[3];
    side0.d   = tc[3][DW-1] ? (~tc[3] + DW'(1)) : tc[3];
    side0.wz  = (tc[3] == '0);
    side0.sat = |clip;
    for (int i = 0; i < 3; i++) begin
      lane0[i].rem = '0;
      lane0[i].neg = tc[i][DW-1] ^ tc[3][DW-1];
      lane0[i].nq  = {(tc[i][DW-1] ? (~tc[i] + DW'(1)) : tc[i]), {F{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane_r[0] <= lane0;
      side_r[0] <= side0;
    end
  end

  // Divider: one restoring step per stage on each of the three lanes.
  for (genvar j = 0; j < QW; j++) begin : g_div
    lane_t lane_nxt [3];
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        logic [DW:0] rs;
        logic [DW:0] diff;
        logic        ge;
        rs   = {lane_r[j][i].rem, lane_r[j][i].nq[QW-1]};
        diff = rs - {1'b0, side_r[j].d};
        ge   = (rs >= {1'b0, side_r[j].d});
        lane_nxt[i].rem = ge ? diff[DW-1:0] : rs[DW-1:0];
        lane_nxt[i].nq  = {lane_r[j][i].nq[QW-2:0], ge};
        lane_nxt[i].neg = lane_r[j][i].neg;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        lane_r[j+1] <= lane_nxt;
        side_r[j+1] <= side_r[j];
      end
    end
  end

  // Final stage: sign, clamp, select the undivided values when w is zero.
  logic signed [QW:0]   qs   [3];
  logic [2:0][DW-1:0]   qo;
  logic [2:0]           qclip;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qs[i] = lane_r[QW][i].neg ? -signed'({1'b0, lane_r[QW][i].nq})
                                :  signed'({1'b0, lane_r[QW][i].nq});
      qclip[i] = 1'b0;
      if (qs[i] > Q_HI) begin
        qo[i] = Q_HI[DW-1:0];
        qclip[i] = 1'b1;
      end else if (qs[i] < Q_LO) begin
        qo[i] = Q_LO[DW-1:0];
        qclip[i] = 1'b1;
      end else begin
        qo[i] = qs[i][DW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (side_r[QW].wz) begin
        out_x     <= FIELD_W'(signed'(side_r[QW].t[0]));
        out_y     <= FIELD_W'(signed'(side_r[QW].t[1]));
        out_z     <= FIELD_W'(signed'(side_r[QW].t[2]));
        saturated <= side_r[QW].sat;
      end else begin
        out_x     <= FIELD_W'(signed'(qo[0]));
        out_y     <= FIELD_W'(signed'(qo[1]));
        out_z     <= FIELD_W'(signed'(qo[2]));
        saturated <= side_r[QW].sat | (|qclip);
      end
      out_w      <= FIELD_W'(signed'(side_r[QW].w));
      w_was_zero <= side_r[QW].wz;
    end
  end

  // Valid bits travel alongside the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r      <= 1'b0;
      vb_r      <= 1'b0;
      out_valid <= 1'b0;
      for (int j = 0; j <= QW; j++) vd_r[j] <= 1'b0;
    end else if (en) begin
      va_r    <= in_valid;
      vb_r    <= va_r;
      vd_r[0] <= vb_r;
      for (int j = 0; j < QW; j++) vd_r[j+1] <= vd_r[j];
      out_valid <= vd_r[QW];
    end
  end

endmodule
`default_nettype wire

/* sv/vtp_checker.sv */
`default_nettype none
module vtp_checker
  import vtp_pkg::*;
(
  input wire               clk,
  input wire               rst_n,
  input wire               in_stall,
  input wire               out_valid,
  input wire               out_stall,
  input wire [FIELD_W-1:0] out_x,
  input wire [FIELD_W-1:0] out_w,
  input wire               w_was_zero
);

  // The input is held back only while a result waits at the output.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a held result");

  a_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_x) && $stable(out_w)))
    else $error("held result changed");

  a_wz_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (w_was_zero == (out_w == '0)))
    else $error("zero w flag disagrees with out_w");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

endmodule

bind vertex_transform_project vtp_checker u_vtp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_x     (out_x),
  .out_w     (out_w),
  .w_was_zero(w_was_zero)
);
`default_nettype wire

/* verif/tb_vertex_transform_project.sv */
`timescale 1ns / 1ps
module tb_vertex_transform_project;
  import vtp_pkg::*;

  typedef struct {
    logic [FIELD_W-1:0] x;
    logic [FIELD_W-1:0] y;
    logic [FIELD_W-1:0] z;
    logic [FIELD_W-1:0] w;
  } vertex_t;

  typedef struct {
    logic [FIELD_W-1:0] x;
    logic [FIELD_W-1:0] y;
    logic [FIELD_W-1:0] z;
    logic [FIELD_W-1:0] w;
    logic               wz;
    logic               sat;
  } projected_t;

  localparam longint Q_MAX = 64'sh7FFF_FFFF;
  localparam longint Q_MIN = -Q_MAX - 1;
  localparam int LATENCY = VTP_DATA_WIDTH + VTP_FRAC_BITS + 4;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [FIELD_W-1:0] in_x, in_y, in_z, in_w;
  logic out_valid;
  logic out_stall;
  logic [FIELD_W-1:0] out_x, out_y, out_z, out_w;
  logic w_was_zero;
  logic saturated;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  vertex_transform_project u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_x(in_x), .in_y(in_y), .in_z(in_z), .in_w(in_w),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_x(out_x), .out_y(out_y), .out_z(out_z), .out_w(out_w),
    .w_was_zero(w_was_zero), .saturated(saturated),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  logic [CFG_W-1:0] matrix_shadow [NUM_REGS];
  vertex_t vertices_to_send[$];
  projected_t awaited_projections[$];
  int errors = 0;
  int n_recv = 0;
  int n_wzero = 0;
  int n_sat = 0;
  bit quiet = 0;

  function automatic longint clamp_q(logic signed [127:0] val, ref bit sat);
    if (val > Q_MAX) begin
      sat = 1;
      return Q_MAX;
    end
    if (val < Q_MIN) begin
      sat = 1;
      return Q_MIN;
    end
    return longint'(val);
  endfunction

  // Exact row sums are kept in 128 bits, so four full-range products never wrap.
  function automatic projected_t project_vertex(vertex_t v);
    logic signed [31:0] comp [4];
    logic signed [31:0] m;
    logic signed [127:0] acc;
    logic signed [127:0] quot;
    longint t [4];
    bit sat;
    projected_t res;
    sat = 0;
    comp[0] = v.x;
    comp[1] = v.y;
    comp[2] = v.z;
    comp[3] = v.w;
    for (int r = 0; r < 4; r++) begin
      acc = 0;
      for (int c = 0; c < 4; c++) begin
        m = matrix_shadow[r * 2 + c / 2][(c % 2) * 32 +: 32];
        acc += m * comp[c];
      end
      t[r] = clamp_q(acc >>> VTP_FRAC_BITS, sat);
    end
    res.wz = (t[3] == 0);
    if (!res.wz) begin
      for (int i = 0; i < 3; i++) begin
        quot = (t[i] <<< VTP_FRAC_BITS) / t[3];
        t[i] = clamp_q(quot, sat);
      end
    end
    res.x = t[0][31:0];
    res.y = t[1][31:0];
    res.z = t[2][31:0];
    res.w = t[3][31:0];
    res.sat = sat;
    return res;
  endfunction

  // Driver: presents the next pending vertex once the current transfer completes.
  int send_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall)
        awaited_projections.push_back(project_vertex('{in_x, in_y, in_z, in_w}));
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          in_valid <= 1'b0;
          send_gap--;
        end else if (vertices_to_send.size() > 0) begin
          vertex_t nv;
          nv = vertices_to_send.pop_front();
          in_x <= nv.x;
          in_y <= nv.y;
          in_z <= nv.z;
          in_w <= nv.w;
          in_valid <= 1'b1;
          if (!quiet && $urandom_range(0, 7) == 0)
            send_gap = $urandom_range(1, 5);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result transfer and shapes the receiver's stall.
  int stall_left = 0;
  int hold_left = 0;
  bit hold_done = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        n_recv++;
        if (awaited_projections.size() == 0) begin
          errors++;
          $display("%0t: unexpected result x=%h y=%h z=%h w=%h", $time,
                   out_x, out_y, out_z, out_w);
        end else begin
          projected_t e;
          e = awaited_projections.pop_front();
          if (w_was_zero) n_wzero++;
          if (saturated) n_sat++;
          if ({out_x, out_y, out_z, out_w, w_was_zero, saturated} !==
              {e.x, e.y, e.z, e.w, e.wz, e.sat}) begin
            errors++;
            $display("%0t: mismatch expected x=%h y=%h z=%h w=%h wz=%b sat=%b", $time,
                     e.x, e.y, e.z, e.w, e.wz, e.sat);
            $display("%0t:          actual   x=%h y=%h z=%h w=%h wz=%b sat=%b", $time,
                     out_x, out_y, out_z, out_w, w_was_zero, saturated);
          end
        end
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (n_recv >= 200 && !hold_done) begin
        // Long hold-off so the pipeline fills and pushes back on the input.
        hold_done = 1;
        hold_left = 250;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if (!quiet && $urandom_range(0, 7) == 0)
          stall_left = $urandom_range(1, 5);
      end
    end
  end

  function automatic logic [31:0] pick_field();
    logic [31:0] specials [7];
    specials = '{32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000,
                 32'hFFFF_0000, 32'h1, 32'hFFFF_FFFF};
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6: return $urandom_range(0, 1 << 20) - (1 << 19);
      7: return specials[$urandom_range(0, 6)];
      default: return $urandom_range(0, 1 << 25) - (1 << 24);
    endcase
  endfunction

  function automatic logic [31:0] pick_coef(int style);
    case (style)
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return $urandom_range(0, 1 << 18) - (1 << 17);
    endcase
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx < NUM_REGS)
      matrix_shadow[idx] = val;
  endtask

  task automatic load_matrix(int style);
    for (int i = 0; i < NUM_REGS; i++)
      write_reg(reg_idx_t'(i), {pick_coef(style), pick_coef(style)});
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_random(int count);
    for (int i = 0; i < count; i++)
      vertices_to_send.push_back('{pick_field(), pick_field(), pick_field(), pick_field()});
  endtask

  task automatic drain();
    do begin
      @(posedge clk);
      #1;
    end while (vertices_to_send.size() > 0 || in_valid || awaited_projections.size() > 0);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_x = '0;
    in_y = '0;
    in_z = '0;
    in_w = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    for (int i = 0; i < NUM_REGS; i++)
      matrix_shadow[i] = COEF_RESET[i];
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Identity matrix: extremes, zero w, negative w and truncation of odd quotients.
    vertices_to_send.push_back('{32'h0, 32'h0, 32'h0, 32'h0});
    vertices_to_send.push_back('{32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0001_0000});
    vertices_to_send.push_back('{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001});
    vertices_to_send.push_back('{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF});
    vertices_to_send.push_back('{32'h0001_0000, 32'hFFFF_0000, 32'h0000_0001, 32'h0003_0000});
    vertices_to_send.push_back('{32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0002, 32'hFFFD_0000});
    vertices_to_send.push_back('{32'h1234_5678, 32'h8765_4321, 32'hDEAD_BEEF, 32'h0});
    vertices_to_send.push_back('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
    vertices_to_send.push_back('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
    vertices_to_send.push_back('{32'h0000_8000, 32'hFFFF_8000, 32'h0, 32'h0002_0000});
    vertices_to_send.push_back('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
    vertices_to_send.push_back('{32'h5555_5555, 32'hAAAA_AAAA, 32'h3333_3333, 32'hCCCC_CCCC});
    drain();

    // Full-range coefficients, plus writes to unused indexes that must be ignored.
    load_matrix(0);
    for (int k = 0; k < 16 - NUM_REGS; k++)
      write_reg(CFG_IDX_W'(NUM_REGS + k), {$urandom, $urandom});
    @(posedge clk);
    cfg_we <= 1'b0;
    queue_random(350);
    drain();

    // Extreme coefficients saturate; then a zero bottom row forces zero w.
    load_matrix(1);
    queue_random(150);
    drain();
    write_reg(REG_R3_C01, '0);
    write_reg(REG_R3_C23, '0);
    @(posedge clk);
    cfg_we <= 1'b0;
    queue_random(100);
    drain();

    // Small coefficients behave like a real projection matrix.
    load_matrix(2);
    queue_random(350);
    drain();

    // All-zero matrix, then back to small values with no idling at all.
    for (int i = 0; i < NUM_REGS; i++)
      write_reg(reg_idx_t'(i), '0);
    @(posedge clk);
    cfg_we <= 1'b0;
    queue_random(50);
    drain();
    load_matrix(2);
    quiet = 1;
    queue_random(450);
    drain();

    repeat (LATENCY + 10) @(posedge clk);
    $display("Checked %0d vertices over seven matrix settings, identity to saturating extremes.",
             n_recv);
    $display("Results with zero w: %0d, results with saturation: %0d.", n_wzero, n_sat);
    if (errors == 0 && awaited_projections.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

endmodule
